/* hw/rtl/rbst_pkg.sv */
// rbst_pkg: shared constants, codes and types of the readback slot tracker
// no dependencies; used by the interfaces and every rbst module

package rbst_pkg;

  // slot table geometry
  localparam int SlotCount = 16;
  localparam int SlotIdxW  = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  localparam int SlotCntW  = $clog2(SlotCount + 1);

  // fixed field widths
  localparam int WordW    = 32;
  localparam int FuncW    = 3;
  localparam int StatusW  = 4;
  localparam int LimitW   = 5;
  localparam int CfgAddrW = 3;

  // width wide enough to compare the occupancy with a 5 bit limit
  localparam int OccW = (SlotCntW > LimitW) ? SlotCntW : LimitW;

  // register reset values
  localparam logic [LimitW-1:0] SlotLimitRst     = LimitW'(16);
  localparam logic [WordW-1:0]  ByteBudgetRst    = WordW'(4194304);
  localparam logic [LimitW-1:0] MapLimitRst      = LimitW'(4);
  localparam logic [WordW-1:0]  DispatchLimitRst = WordW'(1048576);
  localparam logic [WordW-1:0]  HoldLimitRst     = WordW'(100);
  localparam logic [WordW-1:0]  FirstTicket      = WordW'(1);

  typedef enum logic [FuncW-1:0] {
    FuncReserve = 3'd0,
    FuncFence   = 3'd1,
    FuncMap     = 3'd2,
    FuncCancel  = 3'd3,
    FuncRelease = 3'd4,
    FuncHold    = 3'd5
  } func_e;

  typedef enum logic [StatusW-1:0] {
    StOk        = 4'd0,
    StCfg       = 4'd1,
    StSize      = 4'd2,
    StFull      = 4'd3,
    StBudget    = 4'd4,
    StUnknown   = 4'd5,
    StPending   = 4'd6,
    StMapped    = 4'd7,
    StMapLim    = 4'd8,
    StNotMapped = 4'd9,
    StHold      = 4'd10
  } status_e;

  typedef enum logic [CfgAddrW-1:0] {
    CfgSlotLimit     = 3'd0,
    CfgByteBudget    = 3'd1,
    CfgMapLimit      = 3'd2,
    CfgDispatchLimit = 3'd3,
    CfgHoldLimit     = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [LimitW-1:0] slot_limit;
    logic [WordW-1:0]  byte_budget;
    logic [LimitW-1:0] map_limit;
    logic [WordW-1:0]  dispatch_limit;
    logic [WordW-1:0]  hold_limit;
  } cfg_t;

  // lookup results from the slot table
  typedef struct packed {
    logic                hit;
    logic [SlotIdxW-1:0] hit_idx;
    logic [WordW-1:0]    bytes;
    logic                fenced;
    logic                mapped;
    logic [WordW-1:0]    mapped_time;
    logic                free_found;
    logic [SlotCntW-1:0] used;
  } lookup_t;

  // updates to the slot table
  typedef struct packed {
    logic                alloc;
    logic [WordW-1:0]    ticket;
    logic [WordW-1:0]    bytes;
    logic                fence;
    logic                map;
    logic [WordW-1:0]    map_time;
    logic                free;
    logic [SlotIdxW-1:0] idx;
  } update_t;

endpackage

/* hw/rtl/rbst_intf.sv */
// rbst_intf: valid/ready channel interfaces of the readback slot tracker
// depends on rbst_pkg for field widths

// operation beats into the tracker
interface rbst_item_if;
  logic                          valid;
  logic                          ready;
  logic [rbst_pkg::FuncW-1:0]    func;
  logic [rbst_pkg::WordW-1:0]    ticket_in;
  logic [rbst_pkg::WordW-1:0]    request_bytes;
  logic [rbst_pkg::WordW-1:0]    now_ms;

  modport source (output valid, func, ticket_in, request_bytes, now_ms, input ready);
  modport sink   (input valid, func, ticket_in, request_bytes, now_ms, output ready);
endinterface

// result beats out of the tracker
interface rbst_result_if;
  logic                          valid;
  logic                          ready;
  logic [rbst_pkg::StatusW-1:0]  status;
  logic [rbst_pkg::WordW-1:0]    ticket_out;
  logic [rbst_pkg::WordW-1:0]    slot_bytes_out;
  logic [rbst_pkg::WordW-1:0]    committed_out;
  logic [rbst_pkg::LimitW-1:0]   mapped_out;

  modport source (output valid, status, ticket_out, slot_bytes_out, committed_out, mapped_out,
                  input ready);
  modport sink   (input valid, status, ticket_out, slot_bytes_out, committed_out, mapped_out,
                  output ready);
endinterface

// register write beats
interface rbst_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rbst_pkg::CfgAddrW-1:0] addr;
  logic [rbst_pkg::WordW-1:0]    data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

/* hw/rtl/rbst_cfg_regs.sv */
// rbst_cfg_regs: configuration registers and the configuration sanity check
// depends on rbst_pkg and rbst_cfg_if

module rbst_cfg_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  rbst_cfg_if.sink         cfg_i,
  output rbst_pkg::cfg_t   cfg_o,
  output logic             cfg_ok_o
);

  rbst_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;

  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid && cfg_i.ready;

  // register write decode, unknown addresses are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (cfg_i.addr)
        rbst_pkg::CfgSlotLimit:     cfg_d.slot_limit     = cfg_i.data[rbst_pkg::LimitW-1:0];
        rbst_pkg::CfgByteBudget:    cfg_d.byte_budget    = cfg_i.data;
        rbst_pkg::CfgMapLimit:      cfg_d.map_limit      = cfg_i.data[rbst_pkg::LimitW-1:0];
        rbst_pkg::CfgDispatchLimit: cfg_d.dispatch_limit = cfg_i.data;
        rbst_pkg::CfgHoldLimit:     cfg_d.hold_limit     = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slot_limit     <= rbst_pkg::SlotLimitRst;
      cfg_q.byte_budget    <= rbst_pkg::ByteBudgetRst;
      cfg_q.map_limit      <= rbst_pkg::MapLimitRst;
      cfg_q.dispatch_limit <= rbst_pkg::DispatchLimitRst;
      cfg_q.hold_limit     <= rbst_pkg::HoldLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

  // any zero limit or a map limit above the slot limit disables the tracker
  assign cfg_ok_o = (cfg_q.slot_limit != '0) && (cfg_q.byte_budget != '0) &&
                    (cfg_q.map_limit != '0) && (cfg_q.map_limit <= cfg_q.slot_limit) &&
                    (cfg_q.dispatch_limit != '0) && (cfg_q.hold_limit != '0);

endmodule

/* hw/rtl/rbst_slot_table.sv */
// rbst_slot_table: slot entries with parallel ticket match, free slot search
// and occupancy count; depends on rbst_pkg

module rbst_slot_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [rbst_pkg::WordW-1:0]    ticket_i,
  input  rbst_pkg::update_t             upd_i,
  output rbst_pkg::lookup_t             lkp_o
);

  logic [rbst_pkg::SlotCount-1:0]  valid_q;
  logic [rbst_pkg::SlotCntW-1:0]   used_q;
  logic [rbst_pkg::WordW-1:0]      ticket_q [rbst_pkg::SlotCount];
  logic [rbst_pkg::WordW-1:0]      bytes_q  [rbst_pkg::SlotCount];
  logic [rbst_pkg::SlotCount-1:0]  fenced_q;
  logic [rbst_pkg::SlotCount-1:0]  mapped_q;
  logic [rbst_pkg::WordW-1:0]      mtime_q  [rbst_pkg::SlotCount];

  logic                            hit;
  logic [rbst_pkg::SlotIdxW-1:0]   hit_idx;
  logic                            free_found;
  logic [rbst_pkg::SlotIdxW-1:0]   free_idx;

  // ticket match and free search, lowest index wins
  always_comb begin
    hit        = 1'b0;
    hit_idx    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = rbst_pkg::SlotCount - 1; i >= 0; i--) begin
      if (valid_q[i] && (ticket_q[i] == ticket_i)) begin
        hit     = 1'b1;
        hit_idx = rbst_pkg::SlotIdxW'(i);
      end
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = rbst_pkg::SlotIdxW'(i);
      end
    end
  end

  // read the matched entry
  always_comb begin
    lkp_o.hit         = hit;
    lkp_o.hit_idx     = hit_idx;
    lkp_o.bytes       = bytes_q[hit_idx];
    lkp_o.fenced      = fenced_q[hit_idx];
    lkp_o.mapped      = mapped_q[hit_idx];
    lkp_o.mapped_time = mtime_q[hit_idx];
    lkp_o.free_found  = free_found;
    lkp_o.used        = used_q;
  end

  // valid bits and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      used_q  <= '0;
    end else begin
      if (upd_i.alloc) begin
        valid_q[free_idx] <= 1'b1;
        used_q            <= used_q + rbst_pkg::SlotCntW'(1);
      end else if (upd_i.free) begin
        valid_q[upd_i.idx] <= 1'b0;
        used_q             <= used_q - rbst_pkg::SlotCntW'(1);
      end
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    if (upd_i.alloc) begin
      ticket_q[free_idx] <= upd_i.ticket;
      bytes_q[free_idx]  <= upd_i.bytes;
      fenced_q[free_idx] <= 1'b0;
      mapped_q[free_idx] <= 1'b0;
    end
    if (upd_i.fence) begin
      fenced_q[upd_i.idx] <= 1'b1;
    end
    if (upd_i.map) begin
      mapped_q[upd_i.idx] <= 1'b1;
      mtime_q[upd_i.idx]  <= upd_i.map_time;
    end
    if (upd_i.free) begin
      mapped_q[upd_i.idx] <= 1'b0;
    end
  end

  // occupancy counter tracks the valid bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q == rbst_pkg::SlotCntW'($countones(valid_q)))
    else $error("occupancy count out of step with valid bits");

  // a reservation only lands where a free slot exists
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i.alloc |-> free_found && !upd_i.free)
    else $error("slot allocated with no free entry");

endmodule

/* hw/rtl/readback_slot_tracker.sv */
// Readback slot tracker: one operation beat in, one result beat out. An
// operation is held in an input register and resolved from that register
// by a 16-way parallel ticket compare and 32-bit add/subtract logic, with
// the slot table, ticket counter and byte/mapping totals updated at the same
// edge the result is loaded into the output register. A new operation is
// taken every cycle unless a result waits unconsumed, so throughput is one
// beat per cycle; an operation passes through the input register and the
// output register before its result beat is valid, and the output register
// stalls the input register only while a result waits unconsumed.
// Depends on rbst_pkg, rbst_intf, rbst_cfg_regs and rbst_slot_table.

module readback_slot_tracker (
  input  logic            clk_i,
  input  logic            rst_ni,
  rbst_item_if.sink       item_i,
  rbst_result_if.source   result_o,
  rbst_cfg_if.sink        cfg_i
);

  // input register
  logic                          in_vld_q;
  logic [rbst_pkg::FuncW-1:0]    func_q;
  logic [rbst_pkg::WordW-1:0]    tk_q;
  logic [rbst_pkg::WordW-1:0]    req_q;
  logic [rbst_pkg::WordW-1:0]    now_q;

  // output register
  logic                          out_vld_q;
  rbst_pkg::status_e             status_q, status_d;
  logic [rbst_pkg::WordW-1:0]    tout_q, tout_d;
  logic [rbst_pkg::WordW-1:0]    bout_q, bout_d;

  // tracker totals
  logic [rbst_pkg::WordW-1:0]    issue_q, issue_d;
  logic [rbst_pkg::WordW-1:0]    commit_q, commit_d;
  logic [rbst_pkg::LimitW-1:0]   mapped_q, mapped_d;

  rbst_pkg::cfg_t                cfg;
  logic                          cfg_ok;
  rbst_pkg::lookup_t             lkp;
  rbst_pkg::update_t             upd;

  logic                          advance;
  logic                          item_acc;
  logic [rbst_pkg::WordW-1:0]    room;
  logic [rbst_pkg::WordW-1:0]    ret_bytes;
  logic [rbst_pkg::WordW-1:0]    elapsed;
  logic                          size_bad;
  logic                          table_full;

  rbst_cfg_regs u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .cfg_o    (cfg),
    .cfg_ok_o (cfg_ok)
  );

  rbst_slot_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ticket_i (tk_q),
    .upd_i    (upd),
    .lkp_o    (lkp)
  );

  // handshake and pipeline advance
  assign advance      = in_vld_q && (!out_vld_q || result_o.ready);
  assign item_i.ready = !in_vld_q || advance;
  assign item_acc     = item_i.valid && item_i.ready;

  // reserve checks
  assign room       = (commit_q < cfg.byte_budget) ? (cfg.byte_budget - commit_q) : '0;
  assign size_bad   = (req_q == '0) || (req_q > cfg.dispatch_limit);
  assign table_full = (rbst_pkg::OccW'(lkp.used) >= rbst_pkg::OccW'(cfg.slot_limit)) ||
                      !lkp.free_found;

  // bytes handed back by cancel or release, clamped at the total
  assign ret_bytes = (lkp.bytes <= commit_q) ? lkp.bytes : commit_q;
  assign elapsed   = now_q - lkp.mapped_time;

  // operation decode and state update
  always_comb begin
    status_d     = rbst_pkg::StOk;
    tout_d       = '0;
    bout_d       = '0;
    issue_d      = issue_q;
    commit_d     = commit_q;
    mapped_d     = mapped_q;
    upd          = '0;
    upd.idx      = lkp.hit_idx;
    upd.ticket   = issue_q;
    upd.bytes    = req_q;
    upd.map_time = now_q;
    if (!cfg_ok) begin
      status_d = rbst_pkg::StCfg;
    end else if (func_q == rbst_pkg::FuncReserve) begin
      priority if (size_bad) begin
        status_d = rbst_pkg::StSize;
      end else if (table_full) begin
        status_d = rbst_pkg::StFull;
      end else if (req_q > room) begin
        status_d = rbst_pkg::StBudget;
      end else begin
        tout_d    = issue_q;
        issue_d   = (issue_q == '1) ? rbst_pkg::FirstTicket : issue_q + rbst_pkg::WordW'(1);
        commit_d  = commit_q + req_q;
        upd.alloc = advance;
      end
    end else if (!lkp.hit) begin
      // undefined codes without a matching ticket land here too, no entry is touched
      status_d = rbst_pkg::StUnknown;
    end else begin
      case (func_q)
        rbst_pkg::FuncFence: begin
          upd.fence = advance;
        end
        rbst_pkg::FuncMap: begin
          priority if (!lkp.fenced) begin
            status_d = rbst_pkg::StPending;
          end else if (lkp.mapped) begin
            status_d = rbst_pkg::StMapped;
          end else if (mapped_q >= cfg.map_limit) begin
            status_d = rbst_pkg::StMapLim;
          end else begin
            bout_d   = lkp.bytes;
            mapped_d = mapped_q + rbst_pkg::LimitW'(1);
            upd.map  = advance;
          end
        end
        rbst_pkg::FuncCancel: begin
          if (lkp.mapped) begin
            status_d = rbst_pkg::StMapped;
          end else begin
            commit_d = commit_q - ret_bytes;
            upd.free = advance;
          end
        end
        rbst_pkg::FuncRelease: begin
          if (!lkp.mapped) begin
            status_d = rbst_pkg::StNotMapped;
          end else begin
            commit_d = commit_q - ret_bytes;
            mapped_d = (mapped_q != '0) ? mapped_q - rbst_pkg::LimitW'(1) : mapped_q;
            upd.free = advance;
          end
        end
        rbst_pkg::FuncHold: begin
          priority if (!lkp.mapped) begin
            status_d = rbst_pkg::StNotMapped;
          end else if (elapsed > cfg.hold_limit) begin
            status_d = rbst_pkg::StHold;
          end else begin
            status_d = rbst_pkg::StOk;
          end
        end
        default: begin
          status_d = rbst_pkg::StUnknown;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      issue_q   <= rbst_pkg::FirstTicket;
      commit_q  <= '0;
      mapped_q  <= '0;
    end else begin
      if (item_acc) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        issue_q   <= issue_d;
        commit_q  <= commit_d;
        mapped_q  <= mapped_d;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (item_acc) begin
      func_q <= item_i.func;
      tk_q   <= item_i.ticket_in;
      req_q  <= item_i.request_bytes;
      now_q  <= item_i.now_ms;
    end
    if (advance) begin
      status_q <= status_d;
      tout_q   <= tout_d;
      bout_q   <= bout_d;
    end
  end

  // result beat
  assign result_o.valid          = out_vld_q;
  assign result_o.status         = status_q;
  assign result_o.ticket_out     = tout_q;
  assign result_o.slot_bytes_out = bout_q;
  assign result_o.committed_out  = commit_q;
  assign result_o.mapped_out     = mapped_q;

  // ticket zero is never issued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_q != '0)
    else $error("ticket counter reached zero");

  // a result only appears after an operation left the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(in_vld_q))
    else $error("result produced without an operation");

  // a bad configuration leaves the totals alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !cfg_ok |=> $stable(commit_q) && $stable(mapped_q) && $stable(issue_q))
    else $error("state changed under bad configuration");

  // mapped count never exceeds the number of occupied slots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rbst_pkg::OccW'(mapped_q) <= rbst_pkg::OccW'(lkp.used))
    else $error("mapped total above occupancy");

endmodule

/* tb/tb_readback_slot_tracker.sv */
`timescale 1ns / 100ps
// tb_readback_slot_tracker: self-checking bench for the readback slot tracker
// drives operation and register beats, predicts every result beat and compares
// depends on rbst_pkg, the rbst_intf interfaces and readback_slot_tracker

module tb_readback_slot_tracker;

  // func codes the block has no operation for
  localparam logic [rbst_pkg::FuncW-1:0] FuncUndefLo = 3'd6;
  localparam logic [rbst_pkg::FuncW-1:0] FuncUndefHi = 3'd7;

  typedef struct packed {
    logic [rbst_pkg::FuncW-1:0] func;
    logic [rbst_pkg::WordW-1:0] ticket;
    logic [rbst_pkg::WordW-1:0] req;
    logic [rbst_pkg::WordW-1:0] now;
  } op_t;

  typedef struct packed {
    logic [rbst_pkg::StatusW-1:0] status;
    logic [rbst_pkg::WordW-1:0]   ticket;
    logic [rbst_pkg::WordW-1:0]   bytes;
    logic [rbst_pkg::WordW-1:0]   committed;
    logic [rbst_pkg::LimitW-1:0]  mapped;
  } outcome_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  rbst_item_if   item_if ();
  rbst_result_if res_if ();
  rbst_cfg_if    cfg_if ();

  readback_slot_tracker u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // shadow of the register file
  logic [rbst_pkg::LimitW-1:0] lim_slots, lim_maps;
  logic [rbst_pkg::WordW-1:0]  lim_budget, lim_dispatch, lim_hold;

  // shadow of the slot table and totals
  logic                        slot_live   [rbst_pkg::SlotCount];
  logic [rbst_pkg::WordW-1:0]  slot_ticket [rbst_pkg::SlotCount];
  logic [rbst_pkg::WordW-1:0]  slot_bytes  [rbst_pkg::SlotCount];
  logic                        slot_fenced [rbst_pkg::SlotCount];
  logic                        slot_mapped [rbst_pkg::SlotCount];
  logic [rbst_pkg::WordW-1:0]  slot_map_ms [rbst_pkg::SlotCount];
  logic [rbst_pkg::WordW-1:0]  issue_ctr;
  logic [rbst_pkg::WordW-1:0]  committed;
  logic [rbst_pkg::LimitW-1:0] mapped_cnt;

  outcome_t                   outcome_q [$];
  int                         mismatches = 0;
  bit                         idle_on = 1'b1;
  logic [rbst_pkg::WordW-1:0] wall_ms;
  logic [rbst_pkg::WordW-1:0] tk_a, tk_b, tk_c;

  // resolve one operation against the shadow state and return its result beat
  function automatic outcome_t resolve_op(input op_t op);
    outcome_t                   r;
    int                         hit, free_idx, used, cap, i;
    logic [rbst_pkg::WordW-1:0] room;
    logic                       cfg_good;
    r = '0;
    r.status = rbst_pkg::StOk;
    hit = -1;
    free_idx = -1;
    used = 0;
    for (i = 0; i < rbst_pkg::SlotCount; i++) begin
      if (slot_live[i]) begin
        used++;
        if (hit < 0 && slot_ticket[i] == op.ticket) hit = i;
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    cap = (lim_slots < rbst_pkg::SlotCount) ? int'(lim_slots) : rbst_pkg::SlotCount;
    // a budget lowered under the commitment leaves no room
    room = (committed < lim_budget) ? lim_budget - committed : '0;
    cfg_good = lim_slots != 0 && lim_budget != 0 && lim_maps != 0 &&
               lim_maps <= lim_slots && lim_dispatch != 0 && lim_hold != 0;
    if (!cfg_good) begin
      r.status = rbst_pkg::StCfg;
    end else if (op.func == rbst_pkg::FuncReserve) begin
      if (op.req == '0 || op.req > lim_dispatch) r.status = rbst_pkg::StSize;
      else if (used >= cap || free_idx < 0) r.status = rbst_pkg::StFull;
      else if (op.req > room) r.status = rbst_pkg::StBudget;
      else begin
        r.ticket = issue_ctr;
        issue_ctr = issue_ctr + rbst_pkg::WordW'(1);
        if (issue_ctr == '0) issue_ctr = rbst_pkg::FirstTicket;
        slot_live[free_idx]   = 1'b1;
        slot_ticket[free_idx] = r.ticket;
        slot_bytes[free_idx]  = op.req;
        slot_fenced[free_idx] = 1'b0;
        slot_mapped[free_idx] = 1'b0;
        slot_map_ms[free_idx] = '0;
        committed = committed + op.req;
      end
    end else if (op.func > rbst_pkg::FuncHold || hit < 0) begin
      r.status = rbst_pkg::StUnknown;
    end else begin
      case (op.func)
        rbst_pkg::FuncFence: slot_fenced[hit] = 1'b1;
        rbst_pkg::FuncMap: begin
          if (!slot_fenced[hit]) r.status = rbst_pkg::StPending;
          else if (slot_mapped[hit]) r.status = rbst_pkg::StMapped;
          else if (mapped_cnt >= lim_maps) r.status = rbst_pkg::StMapLim;
          else begin
            slot_mapped[hit] = 1'b1;
            slot_map_ms[hit] = op.now;
            mapped_cnt = mapped_cnt + rbst_pkg::LimitW'(1);
            r.bytes = slot_bytes[hit];
          end
        end
        rbst_pkg::FuncCancel: begin
          if (slot_mapped[hit]) r.status = rbst_pkg::StMapped;
          else begin
            committed = committed -
                        ((slot_bytes[hit] <= committed) ? slot_bytes[hit] : committed);
            slot_live[hit] = 1'b0;
          end
        end
        rbst_pkg::FuncRelease: begin
          if (!slot_mapped[hit]) r.status = rbst_pkg::StNotMapped;
          else begin
            committed = committed -
                        ((slot_bytes[hit] <= committed) ? slot_bytes[hit] : committed);
            if (mapped_cnt != 0) mapped_cnt = mapped_cnt - rbst_pkg::LimitW'(1);
            slot_live[hit]   = 1'b0;
            slot_mapped[hit] = 1'b0;
          end
        end
        default: begin
          // elapsed time wraps modulo 2^32
          if (!slot_mapped[hit]) r.status = rbst_pkg::StNotMapped;
          else if (rbst_pkg::WordW'(op.now - slot_map_ms[hit]) > lim_hold)
            r.status = rbst_pkg::StHold;
        end
      endcase
    end
    r.committed = committed;
    r.mapped    = mapped_cnt;
    return r;
  endfunction

  // random live slot index, or -1 when the table is empty
  function automatic int pick_live();
    int idx [$];
    int i;
    for (i = 0; i < rbst_pkg::SlotCount; i++) if (slot_live[i]) idx.push_back(i);
    if (idx.size() == 0) return -1;
    return idx[$urandom_range(idx.size() - 1)];
  endfunction

  // send one operation beat; entered and left at a falling edge
  task automatic send_op(input logic [rbst_pkg::FuncW-1:0] func,
                         input logic [rbst_pkg::WordW-1:0] ticket,
                         input logic [rbst_pkg::WordW-1:0] req,
                         input logic [rbst_pkg::WordW-1:0] now);
    op_t op;
    op = '{func, ticket, req, now};
    while (idle_on && $urandom_range(99) < 6) begin
      item_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_if.valid         <= 1'b1;
    item_if.func          <= func;
    item_if.ticket_in     <= ticket;
    item_if.request_bytes <= req;
    item_if.now_ms        <= now;
    do @(posedge clk_i); while (item_if.ready !== 1'b1);
    outcome_q.push_back(resolve_op(op));
    @(negedge clk_i);
  endtask

  // hold off operations until every result beat is back
  task automatic settle();
    item_if.valid <= 1'b0;
    while (outcome_q.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  // one register write beat, only with the block idle
  task automatic write_reg(input rbst_pkg::cfg_reg_e idx,
                           input logic [rbst_pkg::WordW-1:0] val);
    settle();
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    case (idx)
      rbst_pkg::CfgSlotLimit:     lim_slots    = val[rbst_pkg::LimitW-1:0];
      rbst_pkg::CfgByteBudget:    lim_budget   = val;
      rbst_pkg::CfgMapLimit:      lim_maps     = val[rbst_pkg::LimitW-1:0];
      rbst_pkg::CfgDispatchLimit: lim_dispatch = val;
      rbst_pkg::CfgHoldLimit:     lim_hold     = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_limits(input logic [rbst_pkg::WordW-1:0] slots,
                            input logic [rbst_pkg::WordW-1:0] budget,
                            input logic [rbst_pkg::WordW-1:0] maps,
                            input logic [rbst_pkg::WordW-1:0] dispatch,
                            input logic [rbst_pkg::WordW-1:0] hold);
    write_reg(rbst_pkg::CfgSlotLimit, slots);
    write_reg(rbst_pkg::CfgByteBudget, budget);
    write_reg(rbst_pkg::CfgMapLimit, maps);
    write_reg(rbst_pkg::CfgDispatchLimit, dispatch);
    write_reg(rbst_pkg::CfgHoldLimit, hold);
  endtask

  // each cause of a bad configuration rejects whatever comes in
  task automatic test_bad_config();
    write_reg(rbst_pkg::CfgSlotLimit, '0);
    send_op(rbst_pkg::FuncReserve, '0, 32'd1, '0);
    write_reg(rbst_pkg::CfgSlotLimit, 32'(rbst_pkg::SlotLimitRst));
    write_reg(rbst_pkg::CfgByteBudget, '0);
    send_op(rbst_pkg::FuncFence, 32'd1, '0, '0);
    write_reg(rbst_pkg::CfgByteBudget, rbst_pkg::ByteBudgetRst);
    write_reg(rbst_pkg::CfgMapLimit, '0);
    send_op(rbst_pkg::FuncMap, 32'd1, '0, '0);
    // map limit above slot limit
    write_reg(rbst_pkg::CfgMapLimit, 32'd17);
    send_op(rbst_pkg::FuncCancel, 32'd1, '0, '0);
    write_reg(rbst_pkg::CfgMapLimit, 32'(rbst_pkg::MapLimitRst));
    write_reg(rbst_pkg::CfgDispatchLimit, '0);
    send_op(rbst_pkg::FuncRelease, 32'd1, '0, '0);
    write_reg(rbst_pkg::CfgDispatchLimit, rbst_pkg::DispatchLimitRst);
    write_reg(rbst_pkg::CfgHoldLimit, '0);
    send_op(rbst_pkg::FuncHold, 32'd1, '0, '0);
    write_reg(rbst_pkg::CfgHoldLimit, rbst_pkg::HoldLimitRst);
  endtask

  // size checks and the first three reservations
  task automatic test_reserve_checks();
    send_op(rbst_pkg::FuncReserve, '0, '0, '0);
    send_op(rbst_pkg::FuncReserve, '0, lim_dispatch + 1, '0);
    tk_a = issue_ctr;
    send_op(rbst_pkg::FuncReserve, '1, lim_dispatch, '1);
    tk_b = issue_ctr;
    send_op(rbst_pkg::FuncReserve, '0, 32'd1, '0);
    tk_c = issue_ctr;
    send_op(rbst_pkg::FuncReserve, '0, 32'd2, '0);
  endtask

  // budget lowered under the commitment, then a full table ahead of the budget
  task automatic test_budget_and_full();
    write_reg(rbst_pkg::CfgByteBudget, committed - 1);
    send_op(rbst_pkg::FuncReserve, '0, 32'd1, '0);
    write_reg(rbst_pkg::CfgMapLimit, 32'd3);
    write_reg(rbst_pkg::CfgSlotLimit, 32'd3);
    send_op(rbst_pkg::FuncReserve, '0, 32'd1, '0);
    // slot limit above the table size
    write_reg(rbst_pkg::CfgSlotLimit, 32'd31);
    write_reg(rbst_pkg::CfgMapLimit, 32'(rbst_pkg::MapLimitRst));
    write_reg(rbst_pkg::CfgByteBudget, rbst_pkg::ByteBudgetRst);
  endtask

  // fence, map, hold check, cancel and release on the three slots
  task automatic test_mapping();
    send_op(rbst_pkg::FuncFence, tk_a, '0, '0);
    send_op(rbst_pkg::FuncFence, tk_b, '0, '0);
    send_op(rbst_pkg::FuncMap, tk_c, '0, '0);
    send_op(rbst_pkg::FuncMap, tk_a, '0, 32'hFFFF_FFF0);
    send_op(rbst_pkg::FuncMap, tk_a, '0, 32'hFFFF_FFF0);
    send_op(rbst_pkg::FuncMap, tk_b, '0, '0);
    // map limit lowered below the mapped count
    write_reg(rbst_pkg::CfgMapLimit, 32'd1);
    send_op(rbst_pkg::FuncFence, tk_c, '0, '0);
    send_op(rbst_pkg::FuncMap, tk_c, '0, '0);
    // elapsed time across the wrap, within and just past the hold limit
    send_op(rbst_pkg::FuncHold, tk_a, '0, 32'h0000_000A);
    send_op(rbst_pkg::FuncHold, tk_a, '0, 32'h0000_0055);
    send_op(rbst_pkg::FuncHold, tk_c, '0, '0);
    send_op(rbst_pkg::FuncHold, ~tk_a, '0, '0);
    send_op(rbst_pkg::FuncCancel, tk_a, '0, '0);
    send_op(rbst_pkg::FuncRelease, tk_c, '0, '0);
    send_op(rbst_pkg::FuncRelease, tk_a, '0, '0);
    send_op(rbst_pkg::FuncRelease, tk_b, '0, '0);
    send_op(rbst_pkg::FuncCancel, tk_c, '0, '0);
    send_op(FuncUndefHi, tk_c, '1, '1);
    write_reg(rbst_pkg::CfgMapLimit, 32'(rbst_pkg::MapLimitRst));
  endtask

  // mostly slot lifecycles on live tickets, with some noise mixed in
  task automatic run_phase(input int count, input int reserve_pct,
                           input logic [rbst_pkg::WordW-1:0] size_max);
    logic [rbst_pkg::FuncW-1:0] func;
    logic [rbst_pkg::WordW-1:0] ticket, req, now;
    int                         k, roll, pick, s;
    for (k = 0; k < count; k++) begin
      wall_ms = wall_ms + $urandom_range(40, 0);
      func   = rbst_pkg::FuncReserve;
      ticket = $urandom;
      req    = $urandom;
      now    = wall_ms;
      roll   = $urandom_range(99);
      pick   = $urandom_range(99);
      s      = pick_live();
      if (roll < 3) begin
        func = ($urandom_range(1) != 0) ? FuncUndefHi : FuncUndefLo;
      end else if (roll < 8) begin
        func = rbst_pkg::FuncW'($urandom_range(5, 0));
        now  = $urandom;
      end else if (roll < 8 + reserve_pct || s < 0) begin
        if (pick < 4) req = '0;
        else if (pick < 8) req = lim_dispatch;
        else if (pick >= 12) req = $urandom_range(size_max, 1);
      end else begin
        ticket = slot_ticket[s];
        if (pick < 12) func = rbst_pkg::FuncW'($urandom_range(5, 1));
        else if (!slot_fenced[s])
          func = (pick < 22) ? rbst_pkg::FuncCancel : rbst_pkg::FuncFence;
        else if (!slot_mapped[s])
          func = (pick < 22) ? rbst_pkg::FuncCancel : rbst_pkg::FuncMap;
        else func = (pick < 50) ? rbst_pkg::FuncRelease : rbst_pkg::FuncHold;
        if (pick >= 90) now = $urandom;
      end
      send_op(func, ticket, req, now);
    end
  endtask

  // several limit settings; state carries over so lowered limits bite
  task automatic test_random_traffic();
    set_limits(32'(rbst_pkg::SlotLimitRst), rbst_pkg::ByteBudgetRst,
               32'(rbst_pkg::MapLimitRst), rbst_pkg::DispatchLimitRst,
               rbst_pkg::HoldLimitRst);
    run_phase(400, 30, 32'd600_000);
    set_limits(32'd1, 32'd1000, 32'd1, 32'd500, 32'd1);
    run_phase(200, 30, 32'd600);
    // widest limits, no idling on either side
    idle_on = 1'b0;
    set_limits(32'd31, '1, 32'd16, '1, '1);
    run_phase(450, 50, 32'h3FFF_FFFF);
    idle_on = 1'b1;
    set_limits(32'd16, 32'd4096, 32'd16, 32'd1024, 32'd50);
    run_phase(450, 35, 32'd1200);
  endtask

  task automatic flag(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string field, input logic [rbst_pkg::WordW-1:0] want,
                             input logic [rbst_pkg::WordW-1:0] got);
    if (want !== got) flag($sformatf("%s expected %0h got %0h", field, want, got));
  endtask

  // result sink stalls at random
  always @(negedge clk_i) res_if.ready <= !(idle_on && $urandom_range(99) < 6);

  // compare each result beat with the oldest prediction
  always @(posedge clk_i) begin : chk_beat
    outcome_t want;
    if (rst_ni && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (outcome_q.size() == 0) begin
        flag("result beat with no operation outstanding");
      end else begin
        want = outcome_q.pop_front();
        check_field("status", want.status, res_if.status);
        check_field("ticket_out", want.ticket, res_if.ticket_out);
        check_field("slot_bytes_out", want.bytes, res_if.slot_bytes_out);
        check_field("committed_out", want.committed, res_if.committed_out);
        check_field("mapped_out", want.mapped, res_if.mapped_out);
      end
    end
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int i;
    item_if.valid         = 1'b0;
    item_if.func          = rbst_pkg::FuncReserve;
    item_if.ticket_in     = '0;
    item_if.request_bytes = '0;
    item_if.now_ms        = '0;
    res_if.ready          = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.addr           = rbst_pkg::CfgSlotLimit;
    cfg_if.data           = '0;
    lim_slots    = rbst_pkg::SlotLimitRst;
    lim_budget   = rbst_pkg::ByteBudgetRst;
    lim_maps     = rbst_pkg::MapLimitRst;
    lim_dispatch = rbst_pkg::DispatchLimitRst;
    lim_hold     = rbst_pkg::HoldLimitRst;
    for (i = 0; i < rbst_pkg::SlotCount; i++) begin
      slot_live[i]   = 1'b0;
      slot_ticket[i] = '0;
      slot_bytes[i]  = '0;
      slot_fenced[i] = 1'b0;
      slot_mapped[i] = 1'b0;
      slot_map_ms[i] = '0;
    end
    issue_ctr  = rbst_pkg::FirstTicket;
    committed  = '0;
    mapped_cnt = '0;
    wall_ms    = $urandom;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_bad_config();
    test_reserve_checks();
    test_budget_and_full();
    test_mapping();
    test_random_traffic();
    settle();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && outcome_q.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
